>>> hw/rtl/lrmf_pkg.sv
// ----------------------------------------------------------------------------
// lrmf_pkg: shared types and constants of the line router
// Sizes, status codes and character constants used by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lrmf_pkg;
  localparam int LINE_DEPTH = 1024;
  localparam int BOX_DEPTH  = 1024;
  localparam int BOX_COUNT  = 16;
  localparam int TOKEN_MAX  = 16;

  localparam int LW  = $clog2(LINE_DEPTH);      // line address bits
  localparam int LLW = $clog2(LINE_DEPTH + 1);  // line length bits
  localparam int PW  = $clog2(BOX_DEPTH);       // ring pointer bits
  localparam int BW  = 4;                       // mailbox index bits
  localparam int TW  = $clog2(TOKEN_MAX + 1);   // token length bits

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_LINE     = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_FULL     = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_POP      = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  box_index;
    logic [9:0]  bytes_written;
    logic [7:0]  tx_byte;
    logic        tx_valid;
  } result_t;

  localparam logic [7:0] CH_NL = 8'h0A;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic [7:0] server_ch(input logic [2:0] i);
    case (i)
      3'd0: return 8'h73; 3'd1: return 8'h65; 3'd2: return 8'h72;
      3'd3: return 8'h76; 3'd4: return 8'h65; 3'd5: return 8'h72;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] octopus_ch(input logic [2:0] i);
    case (i)
      3'd0: return 8'h6F; 3'd1: return 8'h63; 3'd2: return 8'h74;
      3'd3: return 8'h6F; 3'd4: return 8'h70; 3'd5: return 8'h75;
      3'd6: return 8'h73;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] panel_ch(input logic [2:0] i);
    case (i)
      3'd0: return 8'h70; 3'd1: return 8'h61; 3'd2: return 8'h6E;
      3'd3: return 8'h65; 3'd4: return 8'h6C;
      default: return 8'h00;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/lrmf_box_ram.sv
// ----------------------------------------------------------------------------
// lrmf_box_ram: mailbox ring storage
// One write port and one registered read port over all mailbox rings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrmf_box_ram (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [lrmf_pkg::BW+lrmf_pkg::PW-1:0] waddr_i,
  input  wire logic [7:0]                           wdata_i,
  input  wire logic [lrmf_pkg::BW+lrmf_pkg::PW-1:0] raddr_i,
  output logic      [7:0]                           rdata_o
);
  import lrmf_pkg::*;
  logic [7:0] mem [BOX_COUNT*BOX_DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/line_router_mailbox_fifos_top.sv
// ----------------------------------------------------------------------------
// line_router_mailbox_fifos_top: line router with mailbox rings
// Gathers bytes into lines and routes each line to a mailbox ring.
// ----------------------------------------------------------------------------
// Usage:
//  Slave channel s_axis_*: one request per handshake. tuser = req_type,
//  tdata = {box_select, rx_byte} (rx_byte low). Master channel m_axis_*:
//  one result per request. tdata packs status, box_index, bytes_written,
//  tx_byte, tx_valid from bit 0 up.
//  A plain byte has its result valid in the cycle after acceptance, and the
//  next request is taken in the cycle after the result handshake. A pop
//  goes through a pointer check, a registered read of the mailbox memory
//  and the result; an empty mailbox skips the read.
//  A newline walks the line through one shared line-memory read port: it
//  scans bytes for blanks and the first word, compares keyword characters
//  (at most 7), reads the panel-number characters, then copies the payload
//  bytes, with setup and wrap-up states around these steps. That single
//  read port sets the rate.
//  s_axis_tready is low while a request is being worked on or while a
//  result waits; a stalled receiver simply holds the result register.
//  Reset clears the line length and all ring pointers; no clearing pass
//  is needed because stores are only read where written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module line_router_mailbox_fifos_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [11:8] box_select
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // status, box_index, bytes_written,
                                          // tx_byte, tx_valid
);
  import lrmf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_POPW, S_SCAN, S_SCANW, S_WORD, S_WORDW,
    S_PANEL, S_PANELW, S_COPY, S_COPYW, S_DONE, S_OUT
  } state_e;

  state_e state_q;
  logic [LLW-1:0] len_q;
  logic [PW-1:0]  rp_q [BOX_COUNT];
  logic [PW-1:0]  wp_q [BOX_COUNT];
  logic [7:0]     line_mem [LINE_DEPTH];
  logic [7:0]     lrd_q;
  logic [LLW-1:0] pos_q, start_q;
  logic [TW-1:0]  tlen_q;
  logic           scan_word_q; // 0 = skipping blanks, 1 = measuring word
  logic           m_srv_q, m_oct_q, m_pan_q, neg_q, digs_q, sign_q;
  logic [9:0]     val_q;
  logic [BW-1:0]  box_q, sel_q;
  logic [9:0]     cnt_q;
  logic           full_q;
  result_t        res_q;
  logic           lwe;
  logic [LW-1:0]  lwaddr, lraddr;
  logic [7:0]     lwdata;
  logic           bwe;
  logic [BW+PW-1:0] bwaddr, braddr;
  logic [7:0]     brd;
  logic [PW-1:0]  wp_next, rp_next;
  logic [BW-1:0]  k_ix;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, res_q.tx_valid, res_q.tx_byte, res_q.bytes_written,
                          res_q.box_index, res_q.status};

  assign k_ix    = (state_q == S_POP || state_q == S_POPW) ? sel_q : box_q;
  assign wp_next = (wp_q[k_ix] == PW'(BOX_DEPTH-1)) ? '0 : wp_q[k_ix] + 1'b1;
  assign rp_next = (rp_q[k_ix] == PW'(BOX_DEPTH-1)) ? '0 : rp_q[k_ix] + 1'b1;

  // line memory
  assign lwe    = (state_q == S_IDLE) && s_axis_tvalid && !s_axis_tuser &&
                  (s_axis_tdata[7:0] != CH_NL) && (len_q < LLW'(LINE_DEPTH));
  assign lwaddr = len_q[LW-1:0];
  assign lwdata = s_axis_tdata[7:0];
  assign lraddr = pos_q[LW-1:0];
  always_ff @(posedge clk_i) begin
    if (lwe) line_mem[lwaddr] <= lwdata;
    lrd_q <= line_mem[lraddr];
  end

  assign bwe    = (state_q == S_COPYW) && (wp_next != rp_q[box_q]);
  assign bwaddr = {box_q, wp_q[box_q]};
  assign braddr = {sel_q, rp_q[sel_q]};

  lrmf_box_ram u_box_ram (
    .clk_i   (clk_i),
    .we_i    (bwe),
    .waddr_i (bwaddr),
    .wdata_i (lrd_q),
    .raddr_i (braddr),
    .rdata_o (brd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      for (int i = 0; i < BOX_COUNT; i++) begin
        rp_q[i] <= '0;
        wp_q[i] <= '0;
      end
      pos_q <= '0; start_q <= '0; tlen_q <= '0; scan_word_q <= 1'b0;
      m_srv_q <= 1'b0; m_oct_q <= 1'b0; m_pan_q <= 1'b0;
      neg_q <= 1'b0; digs_q <= 1'b0; sign_q <= 1'b0; val_q <= '0;
      box_q <= '0; sel_q <= '0; cnt_q <= '0; full_q <= 1'b0;
      res_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sel_q <= s_axis_tdata[11:8];
            if (s_axis_tuser) begin
              res_q <= '0;
              state_q <= S_POP;
            end else if (s_axis_tdata[7:0] != CH_NL) begin
              if (len_q < LLW'(LINE_DEPTH)) begin
                len_q <= len_q + 1'b1;
                res_q <= '{status: ST_STORED, default: '0};
              end else begin
                res_q <= '{status: ST_OVERFLOW, default: '0};
              end
              state_q <= S_OUT;
            end else begin
              res_q <= '0;
              pos_q <= '0; tlen_q <= '0; scan_word_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        S_POP: begin
          res_q.status <= ST_POP;
          if (rp_q[sel_q] != wp_q[sel_q]) state_q <= S_POPW;
          else state_q <= S_OUT;
        end
        S_POPW: begin
          res_q.tx_byte  <= brd;
          res_q.tx_valid <= 1'b1;
          rp_q[sel_q]    <= rp_next;
          state_q        <= S_OUT;
        end
        // find start of word and its length
        S_SCAN: begin
          if (pos_q >= len_q || (scan_word_q && tlen_q == TW'(TOKEN_MAX))) begin
            pos_q <= start_q; m_srv_q <= 1'b1; m_oct_q <= 1'b1; m_pan_q <= 1'b1;
            state_q <= S_WORD;
          end else begin
            state_q <= S_SCANW;
          end
        end
        S_SCANW: begin
          if (!scan_word_q) begin
            if (is_blank(lrd_q)) begin
              pos_q <= pos_q + 1'b1; state_q <= S_SCAN;
            end else begin
              start_q <= pos_q; scan_word_q <= 1'b1; tlen_q <= TW'(1);
              pos_q <= pos_q + 1'b1; state_q <= S_SCAN;
            end
          end else if (is_blank(lrd_q)) begin
            pos_q <= start_q; m_srv_q <= 1'b1; m_oct_q <= 1'b1; m_pan_q <= 1'b1;
            state_q <= S_WORD;
          end else begin
            tlen_q <= tlen_q + 1'b1; pos_q <= pos_q + 1'b1; state_q <= S_SCAN;
          end
        end
        // compare the first up to 7 chars against the keywords
        S_WORD: begin
          if (!scan_word_q || pos_q - start_q == LLW'(7)) begin
            cnt_q <= '0; full_q <= 1'b0; digs_q <= 1'b0;
            if (!scan_word_q) begin
              state_q <= S_DONE;
            end else if (m_srv_q && tlen_q >= TW'(6)) begin
              box_q <= BW'(0); state_q <= S_COPY;
            end else if (m_oct_q && tlen_q >= TW'(7)) begin
              box_q <= BW'(1); state_q <= S_COPY;
            end else if (m_pan_q && tlen_q >= TW'(5)) begin
              pos_q <= start_q + LLW'(5); val_q <= '0; neg_q <= 1'b0;
              sign_q <= 1'b1;
              state_q <= S_PANEL;
            end else begin
              state_q <= S_DONE;
            end
          end else if (pos_q - start_q >= LLW'(tlen_q)) begin
            pos_q <= start_q + LLW'(7); // rest of a short word is not compared
          end else begin
            state_q <= S_WORDW;
          end
        end
        S_WORDW: begin
          if (lrd_q != server_ch(3'(pos_q - start_q)) || pos_q - start_q >= LLW'(6))
            m_srv_q <= m_srv_q && (pos_q - start_q >= LLW'(6));
          if (lrd_q != octopus_ch(3'(pos_q - start_q)))
            m_oct_q <= 1'b0;
          if (lrd_q != panel_ch(3'(pos_q - start_q)) && pos_q - start_q < LLW'(5))
            m_pan_q <= 1'b0;
          pos_q <= pos_q + 1'b1;
          state_q <= S_WORD;
        end
        // parse panel number inside the word
        S_PANEL: begin
          if (pos_q - start_q >= LLW'(tlen_q)) begin
            if ((neg_q && val_q != 10'd0) || (val_q + 10'd2 >= 10'(BOX_COUNT))) begin
              state_q <= S_DONE;
            end else begin
              box_q <= BW'(val_q + 10'd2); state_q <= S_COPY;
            end
          end else begin
            state_q <= S_PANELW;
          end
        end
        S_PANELW: begin
          sign_q <= 1'b0;
          if (sign_q && (lrd_q == 8'h2B || lrd_q == 8'h2D)) begin
            neg_q <= (lrd_q == 8'h2D); pos_q <= pos_q + 1'b1; state_q <= S_PANEL;
          end else if (lrd_q >= 8'h30 && lrd_q <= 8'h39) begin
            val_q <= (val_q > 10'd99) ? 10'd1000 : val_q * 10'd10 + 10'(lrd_q - 8'h30);
            pos_q <= pos_q + 1'b1; state_q <= S_PANEL;
          end else begin
            pos_q <= start_q + LLW'(tlen_q); // stop parsing
          end
          if (!(sign_q && (lrd_q == 8'h2B || lrd_q == 8'h2D)) &&
              !(lrd_q >= 8'h30 && lrd_q <= 8'h39)) state_q <= S_PANEL;
        end
        S_COPY: begin
          if (cnt_q == 10'd0 && !full_q && !digs_q) begin
            pos_q <= start_q + LLW'(tlen_q) + 1'b1; digs_q <= 1'b1;
          end else if (pos_q >= len_q || full_q) begin
            res_q.status <= full_q ? ST_FULL : ST_LINE;
            res_q.box_index <= box_q;
            res_q.bytes_written <= cnt_q;
            len_q <= '0; state_q <= S_OUT;
          end else begin
            state_q <= S_COPYW;
          end
        end
        S_COPYW: begin
          if (wp_next == rp_q[box_q]) begin
            full_q <= 1'b1;
          end else begin
            wp_q[box_q] <= wp_next;
            if (cnt_q != 10'd1023) cnt_q <= cnt_q + 1'b1;
            pos_q <= pos_q + 1'b1;
          end
          state_q <= S_COPY;
        end
        S_DONE: begin
          res_q.status <= ST_UNKNOWN;
          len_q <= '0; state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> verif/line_router_mailbox_fifos_top_test.sv
// ----------------------------------------------------------------------------
// line_router_mailbox_fifos_top_test: self-checking bench of the line router
// Streams bytes and pop requests into the block and compares every result
// with a cycle-free model of line routing and mailbox rings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module line_router_mailbox_fifos_top_test;
  import lrmf_pkg::*;

  localparam int IDLE_PCT = 27;
  localparam int STALL_LIMIT = 20000; // cycles with no handshake at all
  localparam int ITEMS = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  bit calm = 1'b0;  // when set, neither side idles
  int sent = 0;     // requests accepted so far

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  line_router_mailbox_fifos_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Router model plus queue of pending results.
  class router_board;
    logic [7:0] line_mem [LINE_DEPTH];
    int         line_len;
    logic [7:0] ring [BOX_COUNT][BOX_DEPTH];
    int         rd_ptr [BOX_COUNT];
    int         wr_ptr [BOX_COUNT];
    result_t    pending [$];
    int         errors;

    function new();
      line_len = 0;
      errors = 0;
      foreach (rd_ptr[i]) begin
        rd_ptr[i] = 0;
        wr_ptr[i] = 0;
      end
    endfunction

    function bit blank(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function bit word_at(int start, int len, string w);
      if (len < w.len()) return 1'b0;
      for (int i = 0; i < w.len(); i++)
        if (line_mem[start + i] != w[i]) return 1'b0;
      return 1'b1;
    endfunction

    // Mailbox named by the first word, -1 if none.
    function int destination(int start, int len);
      int  i;
      int  val;
      bit  neg;
      i = 5;
      val = 0;
      neg = 1'b0;
      if (len == 0) return -1;
      if (word_at(start, len, "server")) return 0;
      if (word_at(start, len, "octopus")) return 1;
      if (!word_at(start, len, "panel")) return -1;
      if (i < len && (line_mem[start + i] == "+" || line_mem[start + i] == "-")) begin
        neg = line_mem[start + i] == "-";
        i++;
      end
      while (i < len && line_mem[start + i] >= "0" && line_mem[start + i] <= "9") begin
        val = val * 10 + (line_mem[start + i] - "0");
        if (val > 1000) val = 1000;
        i++;
      end
      if (neg && val != 0) return -1;
      if (val + 2 >= BOX_COUNT) return -1;
      return val + 2;
    endfunction

    function void note_request(bit req, logic [7:0] c, logic [3:0] sel);
      result_t r;
      int start, tlen, box, nx;
      r = '0;
      if (req) begin
        r.status = ST_POP;
        if (sel < BOX_COUNT && rd_ptr[sel] != wr_ptr[sel]) begin
          r.tx_byte = ring[sel][rd_ptr[sel]];
          r.tx_valid = 1'b1;
          rd_ptr[sel] = (rd_ptr[sel] + 1) % BOX_DEPTH;
        end
      end else if (c != CH_NL) begin
        if (line_len < LINE_DEPTH) begin
          line_mem[line_len] = c;
          line_len++;
          r.status = ST_STORED;
        end else begin
          r.status = ST_OVERFLOW;
        end
      end else begin
        start = 0;
        tlen = 0;
        while (start < line_len && blank(line_mem[start])) start++;
        while (start + tlen < line_len && tlen < TOKEN_MAX && !blank(line_mem[start + tlen]))
          tlen++;
        box = destination(start, tlen);
        if (box < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          int copied;
          copied = 0;
          r.status = ST_LINE;
          r.box_index = 4'(box);
          for (int p = start + tlen + 1; p < line_len; p++) begin
            nx = (wr_ptr[box] + 1) % BOX_DEPTH;
            if (nx == rd_ptr[box]) begin
              r.status = ST_FULL;
              break;
            end
            ring[box][wr_ptr[box]] = line_mem[p];
            wr_ptr[box] = nx;
            copied++;
          end
          r.bytes_written = 10'(copied > 1023 ? 1023 : copied);
        end
        line_len = 0;
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [31:0] d);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      want = pending.pop_front();
      if (d[2:0] != want.status)
        report($sformatf("status %0d, want %0d", d[2:0], want.status));
      if (d[6:3] != want.box_index)
        report($sformatf("box_index %0d, want %0d", d[6:3], want.box_index));
      if (d[16:7] != want.bytes_written)
        report($sformatf("bytes_written %0d, want %0d", d[16:7], want.bytes_written));
      if (d[24:17] != want.tx_byte)
        report($sformatf("tx_byte %h, want %h", d[24:17], want.tx_byte));
      if (d[25] != want.tx_valid)
        report($sformatf("tx_valid %b, want %b", d[25], want.tx_valid));
      if (d[31:26] != '0)
        report($sformatf("padding bits %h not zero", d[31:26]));
    endtask
  endclass

  router_board board = new();

  // Send one request; inputs move on the falling edge only.
  task automatic push_request(bit req, logic [7:0] c, logic [3:0] sel);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = req;
    s_axis_tdata  = {4'h0, sel, c};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(req, c, sel);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic push_byte(logic [7:0] c);
    push_request(1'b0, c, 4'($urandom_range(15)));
  endtask

  task automatic push_pop(logic [3:0] sel);
    push_request(1'b1, 8'($urandom), sel);
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  // Random printable-or-not payload; newlines excluded so the line stays whole.
  task automatic push_payload(int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom);
      if (c == CH_NL) c = 8'hFF;
      push_byte(c);
    end
  endtask

  // Result side: stall at random, sample at the rising edge.
  always @(negedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);

  // Watchdog: any handshake resets the count.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  string heads [] = '{"server ", "octopus ", "panel0 ", "panel7 ", "panel13 ",
                      "panel+4 ", "panel-0 ", "panel ", "  server\t", "serverx ",
                      "octopusy ", "panel14 ", "panel-2 ", "bogus ", " \t",
                      "panel99999 ", "octo "};

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: each destination form and each odd line shape.
    push_text("server hi\n");
    push_text("octopus \x00\xff\n");
    push_text("panel+13 z\n");
    push_text("panel-0 q\n");
    push_text("panel14 x\n");
    push_text("panel-1 x\n");
    push_text("\n");
    push_text(" \t\r\n");
    push_text("nobody x\n");
    push_text("server\n");               // word ends at the line end
    push_text("serverABCDEFGHIJKLMN\n"); // word cut at the token limit
    push_pop(4'd0);
    push_pop(4'd1);
    push_pop(4'd15);
    push_pop(4'd9);                      // empty mailbox

    // Short line into mailbox 3, then pop part of it back out.
    push_text("panel1 ");
    push_payload(20);
    push_byte(CH_NL);
    repeat (8) push_pop(4'd3);

    // Random part: mostly well-formed lines, some noise and pops.
    while (sent < ITEMS) begin
      calm = (sent >= 220 && sent < 300);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          push_text(heads[$urandom_range(heads.size() - 1)]);
          push_payload($urandom_range(12));
          push_byte(CH_NL);
        end
        5: begin
          push_payload($urandom_range(5));
          if ($urandom_range(1)) push_byte(CH_NL);
        end
        default: begin
          repeat ($urandom_range(1, 6)) push_pop(4'($urandom_range(15)));
        end
      endcase
    end
    calm = 1'b0;
    s_axis_tvalid = 1'b0;

    wait (board.pending.size() == 0);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
